// File: src/apqx_pkg.sv
// Shared types, widths and constants of the attitude PID / quad-X mixer block.
// No dependencies; compile first.
package apqx_pkg;

  // Field widths
  localparam int ANGLE_W   = 16;
  localparam int THR_W     = 11;
  localparam int MOTOR_W   = 11;
  localparam int GAIN_W    = 40;
  localparam int LIMIT_W   = 25;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = GAIN_W;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int GAIN_FRAC_BITS  = 28;
  localparam int OUT_SHIFT       = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

  // Datapath widths
  localparam int ERR_W     = ANGLE_W + 1;          // target - angle
  localparam int SUM_W     = LIMIT_W + 1;          // clamped error sum
  localparam int SUM_RAW_W = SUM_W + 1;            // sum + error before clamp
  localparam int DIFF_W    = ERR_W + 1;            // error - last error
  localparam int OP_W      = SUM_W;                // common multiplier operand
  localparam int GLO_W     = 32;                   // gain split: low part
  localparam int GHI_W     = GAIN_W - GLO_W;       // gain split: high part
  localparam int PLO_W     = GLO_W + 1 + OP_W;
  localparam int PHI_W     = GHI_W + 1 + OP_W;
  localparam int LOSUM_W   = PLO_W + 2;
  localparam int HISUM_W   = PHI_W + 2;
  localparam int ACC_W     = HISUM_W + GLO_W + 1;
  localparam int CORR_W    = ACC_W - OUT_SHIFT;
  localparam int MIX_W     = CORR_W + 3;

  localparam int NUM_AXES  = 3;
  localparam int NUM_TERMS = 3;
  localparam int AXIS_YAW  = 2;
  localparam int TERM_P    = 0;
  localparam int TERM_I    = 1;
  localparam int TERM_D    = 2;

  localparam logic [MOTOR_W-1:0] MOTOR_LOW  = MOTOR_W'(1000);
  localparam logic [MOTOR_W-1:0] MOTOR_HIGH = MOTOR_W'(2000);

  // Register reset values
  localparam logic [GAIN_W-1:0]  TILT_P_RST    = GAIN_W'(64'd402653184);
  localparam logic [GAIN_W-1:0]  TILT_I_RST    = GAIN_W'(64'd13422);
  localparam logic [GAIN_W-1:0]  TILT_D_RST    = GAIN_W'(64'd85899345920);
  localparam logic [GAIN_W-1:0]  YAW_P_RST     = GAIN_W'(64'd536870912);
  localparam logic [GAIN_W-1:0]  YAW_I_RST     = GAIN_W'(64'd33554);
  localparam logic [GAIN_W-1:0]  YAW_D_RST     = GAIN_W'(64'd53687091200);
  localparam logic [LIMIT_W-1:0] SUM_LIMIT_RST = LIMIT_W'(32'd20480000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_PROP  = 3'd0,
    CFG_TILT_INTEG = 3'd1,
    CFG_TILT_DERIV = 3'd2,
    CFG_YAW_PROP   = 3'd3,
    CFG_YAW_INTEG  = 3'd4,
    CFG_YAW_DERIV  = 3'd5,
    CFG_SUM_LIMIT  = 3'd6
  } cfg_idx_t;

endpackage

// File: src/apqx_sample_if.sv
// Input channel of the attitude mixer: one control tick per transaction.
// Depends on apqx_pkg.
interface apqx_sample_if
  import apqx_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] roll_target;
  logic signed [ANGLE_W-1:0] pitch_target;
  logic signed [ANGLE_W-1:0] yaw_target;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic [THR_W-1:0]          throttle_us;
  logic                      armed;

  modport source (
    output valid, roll_target, pitch_target, yaw_target,
           roll_angle, pitch_angle, yaw_angle, throttle_us, armed,
    input  ready
  );
  modport sink (
    input  valid, roll_target, pitch_target, yaw_target,
           roll_angle, pitch_angle, yaw_angle, throttle_us, armed,
    output ready
  );
endinterface

// File: src/apqx_motor_if.sv
// Output channel of the attitude mixer: four motor pulse widths per transaction.
// Depends on apqx_pkg.
interface apqx_motor_if
  import apqx_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MOTOR_W-1:0] motor1_us;
  logic [MOTOR_W-1:0] motor2_us;
  logic [MOTOR_W-1:0] motor3_us;
  logic [MOTOR_W-1:0] motor4_us;

  modport source (
    output valid, motor1_us, motor2_us, motor3_us, motor4_us,
    input  ready
  );
  modport sink (
    input  valid, motor1_us, motor2_us, motor3_us, motor4_us,
    output ready
  );
endinterface

// File: src/attitude_pid_quad_x_mixer_core.sv
// Attitude PID controllers with quad-X motor mixer, top level.
// Depends on apqx_pkg, apqx_sample_if, apqx_motor_if.
//
// One transaction in per clock, one transaction out per clock, while the
// output is not stalled. A tick's result travels through the registered
// stages in order into the output register: the error sums and last
// errors are updated as the tick enters, then one stage forms the split
// gain products (40-bit gains as 32-bit and 8-bit halves), one adds them
// per axis, one recombines and shifts to whole microseconds, and the last
// mixes and clamps into the output register. Each stage holds or advances
// on its own, so ready stays high as long as any stage has a bubble;
// it drops only with all five stages full and the output stalled.
// Disarmed ticks flow through the same stages, leave the state untouched
// and come out as 1000 us on every motor. Gains must be written through a
// plain write port only while the block is idle; the block does not check.
module attitude_pid_quad_x_mixer_core
  import apqx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  apqx_sample_if.sink           sample,
  apqx_motor_if.source          motors,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [GAIN_W-1:0]  tilt_prop_gain;
  logic [GAIN_W-1:0]  tilt_integ_gain;
  logic [GAIN_W-1:0]  tilt_deriv_gain;
  logic [GAIN_W-1:0]  yaw_prop_gain;
  logic [GAIN_W-1:0]  yaw_integ_gain;
  logic [GAIN_W-1:0]  yaw_deriv_gain;
  logic [LIMIT_W-1:0] error_sum_limit;

  // Controller state
  logic signed [SUM_W-1:0] error_sum  [NUM_AXES];
  logic signed [ERR_W-1:0] last_error [NUM_AXES];

  // Stage handshake
  logic [4:0] stage_valid;
  logic [4:0] stage_ready;
  logic       accept;

  // Stage 1: errors, clamped sums, differences
  logic signed [ANGLE_W-1:0]   target   [NUM_AXES];
  logic signed [ANGLE_W-1:0]   angle    [NUM_AXES];
  logic signed [ERR_W-1:0]     err_c    [NUM_AXES];
  logic signed [SUM_RAW_W-1:0] sum_raw  [NUM_AXES];
  logic signed [SUM_W-1:0]     sum_next [NUM_AXES];
  logic signed [DIFF_W-1:0]    diff_c   [NUM_AXES];
  logic signed [SUM_RAW_W-1:0] lim_pos;
  logic signed [SUM_RAW_W-1:0] lim_neg;
  logic signed [OP_W-1:0]      op1 [NUM_AXES][NUM_TERMS];

  // Stage 2: split products
  logic [GAIN_W-1:0]       gain [NUM_AXES][NUM_TERMS];
  logic signed [PLO_W-1:0] plo  [NUM_AXES][NUM_TERMS];
  logic signed [PHI_W-1:0] phi  [NUM_AXES][NUM_TERMS];

  // Stage 3, 4
  logic signed [LOSUM_W-1:0] lo_sum [NUM_AXES];
  logic signed [HISUM_W-1:0] hi_sum [NUM_AXES];
  logic signed [ACC_W-1:0]   acc_c  [NUM_AXES];
  logic signed [CORR_W-1:0]  corr   [NUM_AXES];

  // Side band through the stages
  logic [THR_W-1:0] thr [4];
  logic [3:0]       arm;

  // Stage 5 mix
  logic signed [MIX_W-1:0] base;
  logic signed [MIX_W-1:0] r_mix;
  logic signed [MIX_W-1:0] p_mix;
  logic signed [MIX_W-1:0] y_mix;

  function automatic logic [MOTOR_W-1:0] clamp_motor(input logic signed [MIX_W-1:0] v);
    logic [MOTOR_W-1:0] res;
    if (v < MIX_W'($signed({1'b0, MOTOR_LOW}))) begin
      res = MOTOR_LOW;
    end else if (v > MIX_W'($signed({1'b0, MOTOR_HIGH}))) begin
      res = MOTOR_HIGH;
    end else begin
      res = v[MOTOR_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake: a stage takes new data when empty or when it moves on
  assign stage_ready[4] = !stage_valid[4] || motors.ready;
  assign stage_ready[3] = !stage_valid[3] || stage_ready[4];
  assign stage_ready[2] = !stage_valid[2] || stage_ready[3];
  assign stage_ready[1] = !stage_valid[1] || stage_ready[2];
  assign stage_ready[0] = !stage_valid[0] || stage_ready[1];
  assign sample.ready   = stage_ready[0];
  assign accept         = sample.valid && sample.ready;
  assign motors.valid   = stage_valid[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) stage_valid[0] <= sample.valid;
      if (stage_ready[1]) stage_valid[1] <= stage_valid[0];
      if (stage_ready[2]) stage_valid[2] <= stage_valid[1];
      if (stage_ready[3]) stage_valid[3] <= stage_valid[2];
      if (stage_ready[4]) stage_valid[4] <= stage_valid[3];
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_prop_gain  <= TILT_P_RST;
      tilt_integ_gain <= TILT_I_RST;
      tilt_deriv_gain <= TILT_D_RST;
      yaw_prop_gain   <= YAW_P_RST;
      yaw_integ_gain  <= YAW_I_RST;
      yaw_deriv_gain  <= YAW_D_RST;
      error_sum_limit <= SUM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TILT_PROP:  tilt_prop_gain  <= cfg_data[GAIN_W-1:0];
        CFG_TILT_INTEG: tilt_integ_gain <= cfg_data[GAIN_W-1:0];
        CFG_TILT_DERIV: tilt_deriv_gain <= cfg_data[GAIN_W-1:0];
        CFG_YAW_PROP:   yaw_prop_gain   <= cfg_data[GAIN_W-1:0];
        CFG_YAW_INTEG:  yaw_integ_gain  <= cfg_data[GAIN_W-1:0];
        CFG_YAW_DERIV:  yaw_deriv_gain  <= cfg_data[GAIN_W-1:0];
        CFG_SUM_LIMIT:  error_sum_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: error, clamped error sum and difference, state update on accept
  assign target[0] = sample.roll_target;
  assign target[1] = sample.pitch_target;
  assign target[2] = sample.yaw_target;
  assign angle[0]  = sample.roll_angle;
  assign angle[1]  = sample.pitch_angle;
  assign angle[2]  = sample.yaw_angle;

  assign lim_pos = SUM_RAW_W'($signed({1'b0, error_sum_limit}));
  assign lim_neg = -lim_pos;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      err_c[a]   = ERR_W'(target[a]) - ERR_W'(angle[a]);
      sum_raw[a] = SUM_RAW_W'(error_sum[a]) + SUM_RAW_W'(err_c[a]);
      if (sum_raw[a] > lim_pos) begin
        sum_next[a] = lim_pos[SUM_W-1:0];
      end else if (sum_raw[a] < lim_neg) begin
        sum_next[a] = lim_neg[SUM_W-1:0];
      end else begin
        sum_next[a] = sum_raw[a][SUM_W-1:0];
      end
      diff_c[a] = DIFF_W'(err_c[a]) - DIFF_W'(last_error[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        error_sum[a]  <= '0;
        last_error[a] <= '0;
      end
    end else if (accept && sample.armed) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        error_sum[a]  <= sum_next[a];
        last_error[a] <= err_c[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        op1[a][TERM_P] <= OP_W'(err_c[a]);
        op1[a][TERM_I] <= sum_next[a];
        op1[a][TERM_D] <= OP_W'(diff_c[a]);
      end
      thr[0] <= sample.throttle_us;
      arm[0] <= sample.armed;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain times operand, gain split into low and high parts
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (a == AXIS_YAW) begin
        gain[a][TERM_P] = yaw_prop_gain;
        gain[a][TERM_I] = yaw_integ_gain;
        gain[a][TERM_D] = yaw_deriv_gain;
      end else begin
        gain[a][TERM_P] = tilt_prop_gain;
        gain[a][TERM_I] = tilt_integ_gain;
        gain[a][TERM_D] = tilt_deriv_gain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int t = 0; t < NUM_TERMS; t++) begin
          plo[a][t] <= PLO_W'($signed({1'b0, gain[a][t][GLO_W-1:0]})) * PLO_W'(op1[a][t]);
          phi[a][t] <= PHI_W'($signed({1'b0, gain[a][t][GAIN_W-1:GLO_W]})) *
                       PHI_W'(op1[a][t]);
        end
      end
      thr[1] <= thr[0];
      arm[1] <= arm[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add the three terms of each axis, low and high halves apart
  always_ff @(posedge clk) begin
    if (stage_ready[2]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_sum[a] <= LOSUM_W'(plo[a][TERM_P]) + LOSUM_W'(plo[a][TERM_I]) +
                     LOSUM_W'(plo[a][TERM_D]);
        hi_sum[a] <= HISUM_W'(phi[a][TERM_P]) + HISUM_W'(phi[a][TERM_I]) +
                     HISUM_W'(phi[a][TERM_D]);
      end
      thr[2] <= thr[1];
      arm[2] <= arm[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: recombine and drop the fraction (floor)
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      acc_c[a] = ACC_W'(lo_sum[a]) + (ACC_W'(hi_sum[a]) <<< GLO_W);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[3]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        corr[a] <= acc_c[a][ACC_W-1:OUT_SHIFT];
      end
      thr[3] <= thr[2];
      arm[3] <= arm[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: quad-X mix and clamp into the output register
  assign base  = MIX_W'($signed({1'b0, thr[3]}));
  assign r_mix = MIX_W'(corr[0]);
  assign p_mix = MIX_W'(corr[1]);
  assign y_mix = MIX_W'(corr[2]);

  always_ff @(posedge clk) begin
    if (stage_ready[4]) begin
      if (arm[3]) begin
        motors.motor1_us <= clamp_motor(base - r_mix + p_mix - y_mix);
        motors.motor2_us <= clamp_motor(base + r_mix + p_mix + y_mix);
        motors.motor3_us <= clamp_motor(base - r_mix - p_mix + y_mix);
        motors.motor4_us <= clamp_motor(base + r_mix - p_mix - y_mix);
      end else begin
        motors.motor1_us <= MOTOR_LOW;
        motors.motor2_us <= MOTOR_LOW;
        motors.motor3_us <= MOTOR_LOW;
        motors.motor4_us <= MOTOR_LOW;
      end
    end
  end

`ifndef SYNTH
  // Ready drops only when every stage holds a transaction
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (stage_valid == '1))
    else $error("input stalled with a bubble in the pipeline");

  // A disarmed tick leaves the controller state alone
  a_disarmed_holds_state: assert property (@(posedge clk) disable iff (rst)
    (accept && !sample.armed) |=>
      ($stable(error_sum[0]) && $stable(error_sum[1]) && $stable(error_sum[2]) &&
       $stable(last_error[0]) && $stable(last_error[1]) && $stable(last_error[2])))
    else $error("state changed on a disarmed tick");

  // A result leaving stage four always lands in the output register
  a_stage4_to_output: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[3] && stage_ready[4]) |=> motors.valid)
    else $error("result lost between mix stage and output");

  // Motor outputs stay within the pulse range
  a_motor_range: assert property (@(posedge clk) disable iff (rst)
    motors.valid |->
      (motors.motor1_us >= MOTOR_LOW && motors.motor1_us <= MOTOR_HIGH &&
       motors.motor2_us >= MOTOR_LOW && motors.motor2_us <= MOTOR_HIGH &&
       motors.motor3_us >= MOTOR_LOW && motors.motor3_us <= MOTOR_HIGH &&
       motors.motor4_us >= MOTOR_LOW && motors.motor4_us <= MOTOR_HIGH))
    else $error("motor pulse outside 1000..2000 us");
`endif

endmodule

// File: test/tb_attitude_pid_quad_x_mixer_core.sv
// Self-checking testbench for attitude_pid_quad_x_mixer_core: directed and random
// control ticks under random valid/ready gaps, checked against a cycle-free predictor.
// Depends on apqx_pkg, apqx_sample_if, apqx_motor_if and the core RTL.
module tb_attitude_pid_quad_x_mixer_core;
  import apqx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     AX_ROLL     = 0;
  localparam int     AX_PITCH    = 1;
  localparam int     ANGLE_SPAN  = 23040;          // 180 degrees in 1/128 degree
  localparam int     THR_MIN     = 1000;
  localparam int     THR_MAX     = 2000;
  localparam int     HOLD_CYCLES = 64;
  localparam int     CYCLE_LIMIT = 400000;
  localparam longint PULSE_MIN   = longint'(MOTOR_LOW);
  localparam longint PULSE_MAX   = longint'(MOTOR_HIGH);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_target;
    logic signed [ANGLE_W-1:0] pitch_target;
    logic signed [ANGLE_W-1:0] yaw_target;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic [THR_W-1:0]          throttle_us;
    logic                      armed;
  } tick_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor1_us;
    logic [MOTOR_W-1:0] motor2_us;
    logic [MOTOR_W-1:0] motor3_us;
    logic [MOTOR_W-1:0] motor4_us;
  } pulses_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  apqx_sample_if sample_ch ();
  apqx_motor_if  motor_ch ();

  attitude_pid_quad_x_mixer_core dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .motors    (motor_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Controller copy: gains, limit and per-axis state
  logic [GAIN_W-1:0]        tilt_kp = TILT_P_RST;
  logic [GAIN_W-1:0]        tilt_ki = TILT_I_RST;
  logic [GAIN_W-1:0]        tilt_kd = TILT_D_RST;
  logic [GAIN_W-1:0]        yaw_kp  = YAW_P_RST;
  logic [GAIN_W-1:0]        yaw_ki  = YAW_I_RST;
  logic [GAIN_W-1:0]        yaw_kd  = YAW_D_RST;
  logic [LIMIT_W-1:0]       sum_limit = SUM_LIMIT_RST;
  logic signed [SUM_W-1:0]  err_sum  [NUM_AXES];
  logic signed [ERR_W-1:0]  last_err [NUM_AXES];

  tick_t   pending_ticks [$];
  pulses_t expected_pulses [$];
  int      walk_target [NUM_AXES];
  int      walk_angle  [NUM_AXES];
  int      errors     = 0;
  int      ticks_in   = 0;
  int      cycles     = 0;
  int      press_at   = -1;
  bit      press_done = 1'b0;
  int      hold_left  = 0;
  int      gap_left   = 0;
  int      stall_left = 0;
  bit      idling     = 1'b1;
  logic    in_taken   = 1'b0;

  function automatic longint axis_correction(int axis, logic signed [ANGLE_W-1:0] tgt,
                                             logic signed [ANGLE_W-1:0] ang,
                                             logic [GAIN_W-1:0] kp, ki, kd);
    logic signed [ERR_W-1:0]     e;
    logic signed [SUM_RAW_W-1:0] s;
    logic signed [DIFF_W-1:0]    d;
    logic signed [SUM_RAW_W-1:0] lim;
    logic signed [127:0]         acc;
    e   = ERR_W'(tgt) - ERR_W'(ang);
    s   = SUM_RAW_W'(err_sum[axis]) + SUM_RAW_W'(e);
    lim = SUM_RAW_W'($signed({1'b0, sum_limit}));
    if (s > lim) begin
      s = lim;
    end else if (s < -lim) begin
      s = -lim;
    end
    err_sum[axis]  = SUM_W'(s);
    d              = DIFF_W'(e) - DIFF_W'(last_err[axis]);
    last_err[axis] = e;
    acc = $signed({{(128-GAIN_W){1'b0}}, kp}) * 128'(e)
        + $signed({{(128-GAIN_W){1'b0}}, ki}) * 128'(err_sum[axis])
        + $signed({{(128-GAIN_W){1'b0}}, kd}) * 128'(d);
    return longint'(acc >>> OUT_SHIFT);
  endfunction

  function automatic logic [MOTOR_W-1:0] pulse_clamp(longint v);
    if (v < PULSE_MIN) return MOTOR_LOW;
    if (v > PULSE_MAX) return MOTOR_HIGH;
    return MOTOR_W'(v);
  endfunction

  function automatic pulses_t mix_tick(tick_t t);
    pulses_t p;
    longint  r, pc, y, base;
    if (!t.armed) begin
      p.motor1_us = MOTOR_LOW;
      p.motor2_us = MOTOR_LOW;
      p.motor3_us = MOTOR_LOW;
      p.motor4_us = MOTOR_LOW;
      return p;
    end
    r  = axis_correction(AX_ROLL, t.roll_target, t.roll_angle, tilt_kp, tilt_ki, tilt_kd);
    pc = axis_correction(AX_PITCH, t.pitch_target, t.pitch_angle, tilt_kp, tilt_ki, tilt_kd);
    y  = axis_correction(AXIS_YAW, t.yaw_target, t.yaw_angle, yaw_kp, yaw_ki, yaw_kd);
    base = longint'(t.throttle_us);
    p.motor1_us = pulse_clamp(base - r + pc - y);
    p.motor2_us = pulse_clamp(base + r + pc + y);
    p.motor3_us = pulse_clamp(base - r - pc + y);
    p.motor4_us = pulse_clamp(base + r - pc - y);
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [GAIN_W-1:0] scaled_gain(int lo_bit, int hi_bit);
    logic [63:0] g;
    g = {$urandom, $urandom};
    return GAIN_W'(g >> (63 - $urandom_range(lo_bit, hi_bit)));
  endfunction

  task automatic report_field(string name, logic [MOTOR_W-1:0] want, logic [MOTOR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Check results first, then predict the transaction taken at the same edge
  always @(posedge clk) begin
    pulses_t want;
    tick_t   t;
    in_taken <= sample_ch.valid && sample_ch.ready;
    if (!rst && motor_ch.valid && motor_ch.ready) begin
      if (expected_pulses.size() == 0) begin
        $display("%0t: unexpected motor transaction %0d %0d %0d %0d", $time,
                 motor_ch.motor1_us, motor_ch.motor2_us, motor_ch.motor3_us,
                 motor_ch.motor4_us);
        errors++;
      end else begin
        want = expected_pulses.pop_front();
        report_field("motor1_us", want.motor1_us, motor_ch.motor1_us);
        report_field("motor2_us", want.motor2_us, motor_ch.motor2_us);
        report_field("motor3_us", want.motor3_us, motor_ch.motor3_us);
        report_field("motor4_us", want.motor4_us, motor_ch.motor4_us);
      end
    end
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      t.roll_target  = sample_ch.roll_target;
      t.pitch_target = sample_ch.pitch_target;
      t.yaw_target   = sample_ch.yaw_target;
      t.roll_angle   = sample_ch.roll_angle;
      t.pitch_angle  = sample_ch.pitch_angle;
      t.yaw_angle    = sample_ch.yaw_angle;
      t.throttle_us  = sample_ch.throttle_us;
      t.armed        = sample_ch.armed;
      expected_pulses.push_back(mix_tick(t));
      ticks_in <= ticks_in + 1;
    end
  end

  // Sender: hold an offered tick until taken, then advance
  always @(negedge clk) begin
    tick_t t;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || in_taken) begin
      if (gap_left != 0) begin
        sample_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ticks.size() != 0) begin
        t = pending_ticks.pop_front();
        sample_ch.roll_target  <= t.roll_target;
        sample_ch.pitch_target <= t.pitch_target;
        sample_ch.yaw_target   <= t.yaw_target;
        sample_ch.roll_angle   <= t.roll_angle;
        sample_ch.pitch_angle  <= t.pitch_angle;
        sample_ch.yaw_angle    <= t.yaw_angle;
        sample_ch.throttle_us  <= t.throttle_us;
        sample_ch.armed        <= t.armed;
        sample_ch.valid        <= 1'b1;
        gap_left <= (hold_left != 0) ? 0 : pick_gap();
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (rst || hold_left != 0) begin
      motor_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      motor_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      motor_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Long receiver hold-off so the pipeline fills and backpressures the input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!press_done && ticks_in == press_at) begin
      hold_left  <= HOLD_CYCLES;
      press_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_attitude_pid_quad_x_mixer_core failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_TILT_PROP:  tilt_kp = val[GAIN_W-1:0];
      CFG_TILT_INTEG: tilt_ki = val[GAIN_W-1:0];
      CFG_TILT_DERIV: tilt_kd = val[GAIN_W-1:0];
      CFG_YAW_PROP:   yaw_kp  = val[GAIN_W-1:0];
      CFG_YAW_INTEG:  yaw_ki  = val[GAIN_W-1:0];
      CFG_YAW_DERIV:  yaw_kd  = val[GAIN_W-1:0];
      CFG_SUM_LIMIT:  sum_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_gains(logic [GAIN_W-1:0] tp, ti, td, yp, yi, yd,
                            logic [CFG_DATA_W-1:0] lim);
    write_reg(CFG_TILT_PROP, tp);
    write_reg(CFG_TILT_INTEG, ti);
    write_reg(CFG_TILT_DERIV, td);
    write_reg(CFG_YAW_PROP, yp);
    write_reg(CFG_YAW_INTEG, yi);
    write_reg(CFG_YAW_DERIV, yd);
    write_reg(CFG_SUM_LIMIT, lim);
  endtask

  task automatic put_tick(int rt, int pt, int yt, int ra, int pa, int ya, int thr, bit arm);
    tick_t t;
    t.roll_target  = ANGLE_W'(rt);
    t.pitch_target = ANGLE_W'(pt);
    t.yaw_target   = ANGLE_W'(yt);
    t.roll_angle   = ANGLE_W'(ra);
    t.pitch_angle  = ANGLE_W'(pa);
    t.yaw_angle    = ANGLE_W'(ya);
    t.throttle_us  = THR_W'(thr);
    t.armed        = arm;
    pending_ticks.push_back(t);
  endtask

  // Mostly smooth flight: angles chase targets with noise; the rest is raw noise
  task automatic queue_flight(int n);
    tick_t t;
    int    a;
    int    i;
    repeat (n) begin
      if ($urandom_range(0, 99) < 12) begin
        t.roll_target  = ANGLE_W'($urandom);
        t.pitch_target = ANGLE_W'($urandom);
        t.yaw_target   = ANGLE_W'($urandom);
        t.roll_angle   = ANGLE_W'($urandom);
        t.pitch_angle  = ANGLE_W'($urandom);
        t.yaw_angle    = ANGLE_W'($urandom);
        t.throttle_us  = THR_W'($urandom);
        t.armed        = 1'($urandom);
      end else begin
        for (i = 0; i < NUM_AXES; i++) begin
          if ($urandom_range(0, 9) == 0)
            walk_target[i] = int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
          a = walk_angle[i] + (walk_target[i] - walk_angle[i]) / 8
            + int'($urandom_range(0, 400)) - 200;
          walk_angle[i] = (a > ANGLE_SPAN) ? ANGLE_SPAN : (a < -ANGLE_SPAN) ? -ANGLE_SPAN : a;
        end
        t.roll_target  = ANGLE_W'(walk_target[AX_ROLL]);
        t.pitch_target = ANGLE_W'(walk_target[AX_PITCH]);
        t.yaw_target   = ANGLE_W'(walk_target[AXIS_YAW]);
        t.roll_angle   = ANGLE_W'(walk_angle[AX_ROLL]);
        t.pitch_angle  = ANGLE_W'(walk_angle[AX_PITCH]);
        t.yaw_angle    = ANGLE_W'(walk_angle[AXIS_YAW]);
        t.throttle_us  = THR_W'($urandom_range(THR_MIN, THR_MAX));
        t.armed        = ($urandom_range(0, 19) != 0);
      end
      pending_ticks.push_back(t);
    end
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || sample_ch.valid || expected_pulses.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_AXES; i++) begin
      err_sum[i]     = '0;
      last_err[i]    = '0;
      walk_target[i] = 0;
      walk_angle[i]  = 0;
    end
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.roll_target  = '0;
    sample_ch.pitch_target = '0;
    sample_ch.yaw_target   = '0;
    sample_ch.roll_angle   = '0;
    sample_ch.pitch_angle  = '0;
    sample_ch.yaw_angle    = '0;
    sample_ch.throttle_us  = '0;
    sample_ch.armed        = 1'b0;
    motor_ch.ready         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gains: directed corners, then flight
    put_tick(0, 0, 0, 0, 0, 0, THR_MIN, 0);
    put_tick(0, 0, 0, 0, 0, 0, 1500, 1);
    put_tick(ANGLE_SPAN, 0, 0, -ANGLE_SPAN, 0, 0, 1500, 1);
    put_tick(-ANGLE_SPAN, 0, 0, ANGLE_SPAN, 0, 0, 1500, 1);
    put_tick(0, ANGLE_SPAN, 0, 0, -ANGLE_SPAN, 0, 1500, 1);
    put_tick(0, -ANGLE_SPAN, 0, 0, ANGLE_SPAN, 0, 1500, 1);
    put_tick(0, 0, ANGLE_SPAN, 0, 0, -ANGLE_SPAN, 1500, 1);
    put_tick(0, 0, -ANGLE_SPAN, 0, 0, ANGLE_SPAN, 1500, 1);
    // full 16-bit fields drive the mix past both motor limits
    put_tick(32767, 32767, 32767, -32768, -32768, -32768, 2047, 1);
    put_tick(-32768, -32768, -32768, 32767, 32767, 32767, 0, 1);
    // disarmed with wild inputs must leave the state alone
    put_tick(32767, -32768, 32767, -32768, 32767, -32768, 2047, 0);
    put_tick(0, 0, 0, 0, 0, 0, THR_MAX, 1);
    put_tick(0, 0, 0, 0, 0, 0, THR_MIN, 1);
    put_tick(0, 0, 0, 0, 0, 0, 0, 1);
    put_tick(0, 0, 0, 0, 0, 0, 2047, 1);
    put_tick(100, -100, 50, 0, 0, 0, 1500, 1);
    queue_flight(100);
    settle();

    // All-ones gains and limit; limit data carries bits above its width
    load_gains('1, '1, '1, '1, '1, '1, '1);
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'({$urandom, $urandom}));
    put_tick(ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN, 1500, 1);
    put_tick(-ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN, 1500, 1);
    queue_flight(40);
    settle();

    // Zero gains: motors follow throttle; no idling
    idling = 1'b0;
    load_gains('0, '0, '0, '0, '0, '0, '0);
    queue_flight(40);
    settle();

    // Tight limit so the error sums saturate; long receiver hold-off here
    idling = 1'b1;
    load_gains(TILT_P_RST, TILT_I_RST << 8, TILT_D_RST, YAW_P_RST, YAW_I_RST << 8,
               YAW_D_RST, CFG_DATA_W'(3000));
    press_at = ticks_in + 10;
    queue_flight(100);
    settle();

    repeat (3) begin
      load_gains(scaled_gain(24, 31), scaled_gain(8, 20), scaled_gain(32, 38),
                 scaled_gain(24, 31), scaled_gain(8, 20), scaled_gain(32, 38),
                 CFG_DATA_W'($urandom >> $urandom_range(7, 31)));
      queue_flight(80);
      settle();
    end

    idling = 1'b0;
    load_gains(TILT_P_RST, TILT_I_RST, TILT_D_RST, YAW_P_RST, YAW_I_RST, YAW_D_RST,
               CFG_DATA_W'(SUM_LIMIT_RST));
    queue_flight(80);
    settle();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_attitude_pid_quad_x_mixer_core passed");
    end else begin
      $display("tb_attitude_pid_quad_x_mixer_core failed");
    end
    $finish;
  end

endmodule
